// ----- hw/rtl/gfm_pkg.sv -----
// shared constants, types and state codes for the grid feature map insert block
package gfm_pkg;

    localparam int GRID_SIDE       = 256;
    localparam int FRAME_KEYPOINTS = 64;
    localparam int MAP_CAPACITY    = 65536;

    localparam int GRID_BITS  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_BITS  = $clog2(GRID_DEPTH);

    localparam int CAND_DEPTH = 64;
    localparam int SCAN_BITS  = 6;
    localparam int CNT_BITS   = 7;
    localparam int SLOT_BITS  = 6;
    localparam int STR_BITS   = 16;
    localparam int IDX_BITS   = 17;
    localparam int MAP_BITS   = 16;

    // floor((mm + 50) / 100) via biased reciprocal multiply
    localparam int MM_BIAS     = 32850;
    localparam int Q_ORIGIN    = 328;
    localparam int RECIP       = 167773;
    localparam int RECIP_SHIFT = 24;
    localparam int U_BITS      = 17;
    localparam int R_BITS      = 18;
    localparam int Q_BITS      = 10;
    localparam int CELL_W      = 14;

    typedef struct packed {
        logic [STR_BITS-1:0]  strength;
        logic [SLOT_BITS-1:0] slot;
        logic [GRID_BITS-1:0] row;
        logic [GRID_BITS-1:0] col;
    } cand_t;

    typedef enum logic [13:0] {
        ST_CLR  = 14'b00000000000001,
        ST_IDLE = 14'b00000000000010,
        ST_MULX = 14'b00000000000100,
        ST_MULY = 14'b00000000001000,
        ST_CHK  = 14'b00000000010000,
        ST_GADR = 14'b00000000100000,
        ST_GRDW = 14'b00000001000000,
        ST_SRD  = 14'b00000010000000,
        ST_SCMP = 14'b00000100000000,
        ST_FEND = 14'b00001000000000,
        ST_PRD  = 14'b00010000000000,
        ST_PCMP = 14'b00100000000000,
        ST_EMIT = 14'b01000000000000,
        ST_OUT  = 14'b10000000000000
    } state_t;

endpackage

// ----- hw/rtl/grid_feature_map_insert.sv -----
// top level: sequencer, grid occupancy ram, candidate table and result register
// s_tready stays low while a keypoint runs its multiplies, range check, grid read and candidate scan;
// at frame end one selection pass per chosen cell scans the candidate table, then waits for
// the output to be taken; after reset a clearing pass over GRID_SIDE*GRID_SIDE grid entries
// runs with s_tready low; counters and next map index reset to zero and one
module grid_feature_map_insert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // world_x_mm, world_y_mm, strength
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // cell_col, cell_row, source_slot, map_index, zero pad
    output logic [1:0]  m_tuser,  // selected, map_full
    output logic        m_tlast
);

    localparam int GB = gfm_pkg::GRID_BITS;
    localparam int AB = gfm_pkg::ADDR_BITS;

    gfm_pkg::state_t state_reg, state_next;

    logic signed [15:0]            x_reg, x_next, y_reg, y_next, mm_sel;
    logic [gfm_pkg::STR_BITS-1:0]  str_reg, str_next;
    logic                          fend_reg, fend_next;
    logic [gfm_pkg::SLOT_BITS-1:0] slot_reg, slot_next;
    logic [gfm_pkg::CNT_BITS-1:0]  arrival_reg, arrival_next;
    logic [gfm_pkg::CNT_BITS-1:0]  cand_cnt_reg, cand_cnt_next;
    logic [gfm_pkg::IDX_BITS-1:0]  next_index_reg, next_index_next;
    logic [gfm_pkg::Q_BITS-1:0]    qx_reg, qx_next, q_unit;
    logic [GB-1:0]                 col_reg, col_next, row_reg, row_next;
    logic [gfm_pkg::SCAN_BITS-1:0] scan_reg, scan_next;
    logic [gfm_pkg::CNT_BITS-1:0]  pass_reg, pass_next;
    logic                          bestv_reg, bestv_next;
    gfm_pkg::cand_t                best_reg, best_next, cand_rd, cand_wd;
    logic [2*GB-1:0]               prev_key_reg, prev_key_next, key;
    logic [AB-1:0]                 clr_reg, clr_next;

    logic                          o_sel_reg, o_sel_next, o_full_reg, o_full_next;
    logic                          o_last_reg, o_last_next;
    logic [7:0]                    o_col_reg, o_col_next, o_row_reg, o_row_next;
    logic [gfm_pkg::SLOT_BITS-1:0] o_slot_reg, o_slot_next;
    logic [gfm_pkg::MAP_BITS-1:0]  o_idx_reg, o_idx_next;

    logic signed [gfm_pkg::CELL_W-1:0] cx, cy;
    logic                          cx_in, cy_in, full, scan_end, hit, qual;
    logic                          grid_we, grid_rd;
    logic [AB-1:0]                 grid_waddr, grid_raddr;
    logic [0:0]                    grid_wd;
    logic                          cand_we;
    logic [gfm_pkg::SCAN_BITS-1:0] cand_waddr;

    assign s_tready = (state_reg == gfm_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == gfm_pkg::ST_OUT);
    assign m_tdata  = {2'b00, o_idx_reg, o_slot_reg, o_row_reg, o_col_reg};
    assign m_tuser  = {o_full_reg, o_sel_reg};
    assign m_tlast  = o_last_reg;

    assign mm_sel = (state_reg == gfm_pkg::ST_MULY) ? y_reg : x_reg;

    gfm_cell_unit u_cell (
        .aclk  (aclk),
        .mm    (mm_sel),
        .q_reg (q_unit)
    );

    gfm_ram #(.WIDTH(1), .DEPTH(gfm_pkg::GRID_DEPTH)) u_grid (
        .aclk  (aclk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wd),
        .raddr (grid_raddr),
        .rdata (grid_rd)
    );

    gfm_ram #(.WIDTH($bits(gfm_pkg::cand_t)), .DEPTH(gfm_pkg::CAND_DEPTH)) u_cand (
        .aclk  (aclk),
        .we    (cand_we),
        .waddr (cand_waddr),
        .wdata (cand_wd),
        .raddr (scan_reg),
        .rdata (cand_rd)
    );

    assign cx = $signed({{(gfm_pkg::CELL_W-gfm_pkg::Q_BITS){1'b0}}, qx_reg})
              - gfm_pkg::CELL_W'(gfm_pkg::Q_ORIGIN) + gfm_pkg::CELL_W'(gfm_pkg::GRID_SIDE / 2);
    assign cy = $signed({{(gfm_pkg::CELL_W-gfm_pkg::Q_BITS){1'b0}}, q_unit})
              - gfm_pkg::CELL_W'(gfm_pkg::Q_ORIGIN) + gfm_pkg::CELL_W'(gfm_pkg::GRID_SIDE / 2);
    assign cx_in = (cx >= 0) && (cx < $signed(gfm_pkg::CELL_W'(gfm_pkg::GRID_SIDE)));
    assign cy_in = (cy >= 0) && (cy < $signed(gfm_pkg::CELL_W'(gfm_pkg::GRID_SIDE)));

    assign grid_raddr = AB'(row_reg) * AB'(gfm_pkg::GRID_SIDE) + AB'(col_reg);
    assign full       = (next_index_reg == gfm_pkg::IDX_BITS'(gfm_pkg::MAP_CAPACITY));
    assign scan_end   = ({1'b0, scan_reg} + 1'b1) == cand_cnt_reg;
    assign hit        = (cand_rd.col == col_reg) && (cand_rd.row == row_reg);
    assign key        = {cand_rd.row, cand_rd.col};
    assign qual       = ((pass_reg == '0) || (key > prev_key_reg))
                      && (!bestv_reg || (key < {best_reg.row, best_reg.col}));

    assign cand_wd.strength = str_reg;
    assign cand_wd.slot     = slot_reg;
    assign cand_wd.row      = row_reg;
    assign cand_wd.col      = col_reg;

    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        str_next        = str_reg;
        fend_next       = fend_reg;
        slot_next       = slot_reg;
        arrival_next    = arrival_reg;
        cand_cnt_next   = cand_cnt_reg;
        next_index_next = next_index_reg;
        qx_next         = qx_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        scan_next       = scan_reg;
        pass_next       = pass_reg;
        bestv_next      = bestv_reg;
        best_next       = best_reg;
        prev_key_next   = prev_key_reg;
        clr_next        = clr_reg;
        o_sel_next      = o_sel_reg;
        o_col_next      = o_col_reg;
        o_row_next      = o_row_reg;
        o_slot_next     = o_slot_reg;
        o_idx_next      = o_idx_reg;
        o_full_next     = o_full_reg;
        o_last_next     = o_last_reg;
        grid_we         = 1'b0;
        grid_waddr      = AB'(best_reg.row) * AB'(gfm_pkg::GRID_SIDE) + AB'(best_reg.col);
        grid_wd         = 1'b1;
        cand_we         = 1'b0;
        cand_waddr      = cand_cnt_reg[gfm_pkg::SCAN_BITS-1:0];

        case (state_reg)
            gfm_pkg::ST_CLR: begin
                grid_we    = 1'b1;
                grid_waddr = clr_reg;
                grid_wd    = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == AB'(gfm_pkg::GRID_DEPTH - 1)) begin
                    state_next = gfm_pkg::ST_IDLE;
                end
            end
            gfm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    x_next    = s_tdata[15:0];
                    y_next    = s_tdata[31:16];
                    str_next  = s_tdata[47:32];
                    fend_next = s_tlast;
                    slot_next = arrival_reg[gfm_pkg::SLOT_BITS-1:0];
                    if (arrival_reg < gfm_pkg::CNT_BITS'(gfm_pkg::FRAME_KEYPOINTS)) begin
                        arrival_next = arrival_reg + 1'b1;
                        state_next   = gfm_pkg::ST_MULX;
                    end else begin
                        state_next = gfm_pkg::ST_FEND;
                    end
                end
            end
            gfm_pkg::ST_MULX: begin
                state_next = gfm_pkg::ST_MULY;
            end
            gfm_pkg::ST_MULY: begin
                qx_next    = q_unit;
                state_next = gfm_pkg::ST_CHK;
            end
            gfm_pkg::ST_CHK: begin
                col_next = cx[GB-1:0];
                row_next = cy[GB-1:0];
                if (cx_in && cy_in) begin
                    state_next = gfm_pkg::ST_GADR;
                end else begin
                    state_next = gfm_pkg::ST_FEND;
                end
            end
            gfm_pkg::ST_GADR: begin
                scan_next  = '0;
                state_next = gfm_pkg::ST_GRDW;
            end
            gfm_pkg::ST_GRDW: begin
                if (grid_rd) begin
                    state_next = gfm_pkg::ST_FEND;
                end else if (cand_cnt_reg == '0) begin
                    cand_we       = 1'b1;
                    cand_cnt_next = cand_cnt_reg + 1'b1;
                    state_next    = gfm_pkg::ST_FEND;
                end else begin
                    state_next = gfm_pkg::ST_SRD;
                end
            end
            gfm_pkg::ST_SRD: begin
                state_next = gfm_pkg::ST_SCMP;
            end
            gfm_pkg::ST_SCMP: begin
                if (hit) begin
                    cand_we    = (str_reg > cand_rd.strength);
                    cand_waddr = scan_reg;
                    state_next = gfm_pkg::ST_FEND;
                end else if (scan_end) begin
                    cand_we       = 1'b1;
                    cand_cnt_next = cand_cnt_reg + 1'b1;
                    state_next    = gfm_pkg::ST_FEND;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = gfm_pkg::ST_SRD;
                end
            end
            gfm_pkg::ST_FEND: begin
                scan_next  = '0;
                pass_next  = '0;
                bestv_next = 1'b0;
                if (!fend_reg) begin
                    state_next = gfm_pkg::ST_IDLE;
                end else if (cand_cnt_reg == '0) begin
                    o_sel_next  = 1'b0;
                    o_col_next  = '0;
                    o_row_next  = '0;
                    o_slot_next = '0;
                    o_idx_next  = '0;
                    o_full_next = 1'b0;
                    o_last_next = 1'b1;
                    state_next  = gfm_pkg::ST_OUT;
                end else begin
                    state_next = gfm_pkg::ST_PRD;
                end
            end
            gfm_pkg::ST_PRD: begin
                state_next = gfm_pkg::ST_PCMP;
            end
            gfm_pkg::ST_PCMP: begin
                if (qual) begin
                    bestv_next = 1'b1;
                    best_next  = cand_rd;
                end
                if (scan_end) begin
                    state_next = gfm_pkg::ST_EMIT;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = gfm_pkg::ST_PRD;
                end
            end
            gfm_pkg::ST_EMIT: begin
                o_sel_next    = 1'b1;
                o_col_next    = 8'(best_reg.col);
                o_row_next    = 8'(best_reg.row);
                o_slot_next   = best_reg.slot;
                o_full_next   = full;
                o_idx_next    = full ? '0 : next_index_reg[gfm_pkg::MAP_BITS-1:0];
                o_last_next   = (pass_reg + 1'b1) == cand_cnt_reg;
                grid_we       = !full;
                if (!full) begin
                    next_index_next = next_index_reg + 1'b1;
                end
                prev_key_next = {best_reg.row, best_reg.col};
                pass_next     = pass_reg + 1'b1;
                state_next    = gfm_pkg::ST_OUT;
            end
            gfm_pkg::ST_OUT: begin
                if (m_tready) begin
                    scan_next  = '0;
                    bestv_next = 1'b0;
                    if (o_last_reg) begin
                        cand_cnt_next = '0;
                        arrival_next  = '0;
                        state_next    = gfm_pkg::ST_IDLE;
                    end else begin
                        state_next = gfm_pkg::ST_PRD;
                    end
                end
            end
            default: begin
                state_next = gfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gfm_pkg::ST_CLR;
            arrival_reg    <= '0;
            cand_cnt_reg   <= '0;
            next_index_reg <= gfm_pkg::IDX_BITS'(1);
            clr_reg        <= '0;
            scan_reg       <= '0;
            pass_reg       <= '0;
            bestv_reg      <= 1'b0;
            o_last_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            arrival_reg    <= arrival_next;
            cand_cnt_reg   <= cand_cnt_next;
            next_index_reg <= next_index_next;
            clr_reg        <= clr_next;
            scan_reg       <= scan_next;
            pass_reg       <= pass_next;
            bestv_reg      <= bestv_next;
            o_last_reg     <= o_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        str_reg      <= str_next;
        fend_reg     <= fend_next;
        slot_reg     <= slot_next;
        qx_reg       <= qx_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        best_reg     <= best_next;
        prev_key_reg <= prev_key_next;
        o_sel_reg    <= o_sel_next;
        o_col_reg    <= o_col_next;
        o_row_reg    <= o_row_next;
        o_slot_reg   <= o_slot_next;
        o_idx_reg    <= o_idx_next;
        o_full_reg   <= o_full_next;
    end

    a_cand_le_arrival: assert property (@(posedge aclk) disable iff (!aresetn)
        cand_cnt_reg <= arrival_reg)
        else $error("candidate count above arrivals");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        next_index_reg >= gfm_pkg::IDX_BITS'(1)
        && next_index_reg <= gfm_pkg::IDX_BITS'(gfm_pkg::MAP_CAPACITY))
        else $error("map index out of range");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1])
        else $error("empty frame beat not final");

    a_grid_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        grid_we |-> (state_reg == gfm_pkg::ST_EMIT || state_reg == gfm_pkg::ST_CLR))
        else $error("unexpected grid write");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gfm_pkg::ST_CLR |=> !(m_tvalid && $past(s_tvalid && s_tready)))
        else $error("beat during clearing pass");

endmodule

// ----- hw/rtl/gfm_ram.sv -----
// generic single write port ram with registered read
module gfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/gfm_cell_unit.sv -----
// shared reciprocal multiplier mapping a millimetre position to a biased cell quotient
module gfm_cell_unit (
    input  logic                        aclk,
    input  logic signed [15:0]          mm,
    output logic [gfm_pkg::Q_BITS-1:0]  q_reg
);

    logic [gfm_pkg::U_BITS-1:0]                  u;
    logic [gfm_pkg::U_BITS+gfm_pkg::R_BITS-1:0]  prod;

    assign u    = {mm[15], mm} + gfm_pkg::U_BITS'(gfm_pkg::MM_BIAS);
    assign prod = (gfm_pkg::U_BITS+gfm_pkg::R_BITS)'(u)
                * (gfm_pkg::U_BITS+gfm_pkg::R_BITS)'(gfm_pkg::RECIP);

    always_ff @(posedge aclk) begin
        q_reg <= prod[gfm_pkg::RECIP_SHIFT +: gfm_pkg::Q_BITS];
    end

endmodule
